/* hw/rtl/hcrd_pkg.sv */
// Shared types and constants for the chunked response deframer.
package hcrd_pkg;

   // Error codes reported with each result word.
   typedef enum logic [2:0] {
      ERR_NONE        = 3'd0,
      ERR_BAD_STATUS  = 3'd1,
      ERR_EMPTY_SIZE  = 3'd2,
      ERR_MISSING_CRLF = 3'd3,
      ERR_SIZE_OVERFLOW = 3'd4,
      ERR_BUSY_ARM    = 3'd5,
      ERR_IDLE_BYTE   = 3'd6
   } error_type;

   // Input word kinds.
   localparam logic KIND_ARM  = 1'b0;
   localparam logic KIND_BYTE = 1'b1;

   // One result word of the decoder.
   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       chunk_last;
      logic       header_done;
      logic       response_done;
      error_type  error_code;
   } result_type;

endpackage

/* hw/rtl/hcrd_decoder.sv */
// Per-byte decoder state machine: status match, header scan, chunk framing.
module hcrd_decoder #(
   parameter int SIZE_DIGITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               kind,
   input  logic [7:0]         data,
   output hcrd_pkg::result_type result
);
   import hcrd_pkg::*;

   localparam int AW = 4 * SIZE_DIGITS;
   localparam int CW = $clog2(SIZE_DIGITS + 1);
   localparam int STATUS_LEN = 17;
   localparam logic [7:0] CR = 8'd13;
   localparam logic [7:0] LF = 8'd10;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_STATUS  = 4'd1,
      PH_HEADER  = 4'd2,
      PH_SIZE    = 4'd3,
      PH_SIZE_LF = 4'd4,
      PH_DATA    = 4'd5,
      PH_DATA_CR = 4'd6,
      PH_DATA_LF = 4'd7,
      PH_LAST_CR = 4'd8,
      PH_LAST_LF = 4'd9
   } phase_type;

   // Expected status line, one character per index.
   function automatic logic [7:0] status_char(input logic [4:0] idx);
      logic [7:0] c;
      case (idx)
         5'd0:    c = "H";
         5'd1:    c = "T";
         5'd2:    c = "T";
         5'd3:    c = "P";
         5'd4:    c = "/";
         5'd5:    c = "1";
         5'd6:    c = ".";
         5'd7:    c = "1";
         5'd8:    c = " ";
         5'd9:    c = "2";
         5'd10:   c = "0";
         5'd11:   c = "0";
         5'd12:   c = " ";
         5'd13:   c = "O";
         5'd14:   c = "K";
         5'd15:   c = CR;
         5'd16:   c = LF;
         default: c = 8'd0;
      endcase
      return c;
   endfunction

   // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c >= "0" && c <= "9") begin
         v = {1'b1, 4'(c - "0")};
      end else if (c >= "a" && c <= "f") begin
         v = {1'b1, 4'(c - "a" + 8'd10)};
      end else if (c >= "A" && c <= "F") begin
         v = {1'b1, 4'(c - "A" + 8'd10)};
      end else begin
         v = 5'd0;
      end
      return v;
   endfunction

   phase_type      phase_ff, phase_in;
   logic [4:0]     match_idx_ff, match_idx_in;
   logic [1:0]     crlf_ff, crlf_in;
   logic [AW-1:0]  size_acc_ff, size_acc_in;
   logic [AW-1:0]  remaining_ff, remaining_in;
   logic [CW-1:0]  digit_count_ff, digit_count_in;
   logic           in_ext_ff, in_ext_in;
   logic [4:0]     hex;

   assign hex = hex_value(data);

   // Next state and result for the word at the input register.
   always_comb begin
      logic go_idle;
      go_idle        = 1'b0;
      phase_in       = phase_ff;
      match_idx_in   = match_idx_ff;
      crlf_in        = crlf_ff;
      size_acc_in    = size_acc_ff;
      remaining_in   = remaining_ff;
      digit_count_in = digit_count_ff;
      in_ext_in      = in_ext_ff;
      result         = '0;

      if (kind == KIND_ARM) begin
         if (phase_ff == PH_IDLE) begin
            go_idle  = 1'b1;
         end else begin
            result.error_code = ERR_BUSY_ARM;
            go_idle  = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_STATUS: begin
               if (match_idx_ff < 5'(STATUS_LEN) && data == status_char(match_idx_ff)) begin
                  match_idx_in = match_idx_ff + 5'd1;
                  if (match_idx_ff == 5'(STATUS_LEN - 1)) begin
                     phase_in = PH_HEADER;
                     crlf_in  = 2'd2;
                  end
               end else begin
                  result.error_code = ERR_BAD_STATUS;
                  go_idle = 1'b1;
               end
            end
            PH_HEADER: begin
               // Track CR LF CR LF; a status line ending counts as the first pair.
               if (data == CR) begin
                  crlf_in = (crlf_ff == 2'd2) ? 2'd3 : 2'd1;
               end else if (data == LF) begin
                  if (crlf_ff == 2'd1) begin
                     crlf_in = 2'd2;
                  end else if (crlf_ff == 2'd3) begin
                     result.header_done = 1'b1;
                     crlf_in        = 2'd0;
                     phase_in       = PH_SIZE;
                     size_acc_in    = '0;
                     digit_count_in = '0;
                     in_ext_in      = 1'b0;
                  end else begin
                     crlf_in = 2'd0;
                  end
               end else begin
                  crlf_in = 2'd0;
               end
            end
            PH_SIZE: begin
               if (in_ext_ff) begin
                  if (data == CR) begin
                     phase_in = PH_SIZE_LF;
                  end
               end else if (hex[4]) begin
                  if (digit_count_ff >= CW'(SIZE_DIGITS)) begin
                     result.error_code = ERR_SIZE_OVERFLOW;
                     go_idle = 1'b1;
                  end else begin
                     size_acc_in    = (size_acc_ff << 4) | AW'(hex[3:0]);
                     digit_count_in = digit_count_ff + CW'(1);
                  end
               end else if (digit_count_ff == '0) begin
                  result.error_code = ERR_EMPTY_SIZE;
                  go_idle = 1'b1;
               end else if (data == CR) begin
                  phase_in = PH_SIZE_LF;
               end else begin
                  in_ext_in = 1'b1;
               end
            end
            PH_SIZE_LF: begin
               if (data != LF) begin
                  result.error_code = ERR_MISSING_CRLF;
                  go_idle = 1'b1;
               end else if (size_acc_ff == '0) begin
                  phase_in = PH_LAST_CR;
               end else begin
                  remaining_in = size_acc_ff;
                  phase_in     = PH_DATA;
               end
            end
            PH_DATA: begin
               result.payload_valid = 1'b1;
               result.payload_byte  = data;
               if (remaining_ff <= AW'(1)) begin
                  result.chunk_last = 1'b1;
                  remaining_in      = '0;
                  phase_in          = PH_DATA_CR;
               end else begin
                  remaining_in = remaining_ff - AW'(1);
               end
            end
            PH_DATA_CR, PH_LAST_CR: begin
               if (data == CR) begin
                  phase_in = (phase_ff == PH_DATA_CR) ? PH_DATA_LF : PH_LAST_LF;
               end else begin
                  result.error_code = ERR_MISSING_CRLF;
                  go_idle = 1'b1;
               end
            end
            PH_DATA_LF: begin
               if (data == LF) begin
                  phase_in       = PH_SIZE;
                  size_acc_in    = '0;
                  digit_count_in = '0;
                  in_ext_in      = 1'b0;
               end else begin
                  result.error_code = ERR_MISSING_CRLF;
                  go_idle = 1'b1;
               end
            end
            PH_LAST_LF: begin
               if (data == LF) begin
                  result.response_done = 1'b1;
               end else begin
                  result.error_code = ERR_MISSING_CRLF;
               end
               go_idle = 1'b1;
            end
            default: begin
               result.error_code = ERR_IDLE_BYTE;
               go_idle = 1'b1;
            end
         endcase
      end

      // Any error or completion returns all state to its reset value.
      if (go_idle) begin
         phase_in       = PH_IDLE;
         match_idx_in   = '0;
         crlf_in        = '0;
         size_acc_in    = '0;
         remaining_in   = '0;
         digit_count_in = '0;
         in_ext_in      = 1'b0;
         // A clean arm moves on to the status line.
         if (kind == KIND_ARM && phase_ff == PH_IDLE) begin
            phase_in = PH_STATUS;
         end
      end
   end

   // Decoder state, advanced once per word.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         match_idx_ff   <= '0;
         crlf_ff        <= '0;
         size_acc_ff    <= '0;
         remaining_ff   <= '0;
         digit_count_ff <= '0;
         in_ext_ff      <= 1'b0;
      end else if (step) begin
         phase_ff       <= phase_in;
         match_idx_ff   <= match_idx_in;
         crlf_ff        <= crlf_in;
         size_acc_ff    <= size_acc_in;
         remaining_ff   <= remaining_in;
         digit_count_ff <= digit_count_in;
         in_ext_ff      <= in_ext_in;
      end
   end

endmodule

/* hw/rtl/hcrd_out_reg.sv */
// Result register that holds a word until the receiver takes it.
module hcrd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  hcrd_pkg::result_type result,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output hcrd_pkg::result_type held
);
   import hcrd_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign rsp_tvalid = valid_ff;
   assign held       = data_ff;

   // Valid flag: set on load, cleared once the word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule

/* hw/rtl/http_chunked_response_deframer_core.sv */
// Top level of the HTTP/1.1 chunked response deframer.
//
// Usage: each input word on the req_ channel is either an arm event
// (req_tuser = 0, a request was sent) or one received response byte
// (req_tuser = 1, byte in req_tdata). Every input word produces exactly
// one result word on the rsp_ channel: a payload byte flagged by
// rsp_tuser with rsp_tlast on the last byte of each chunk, plus header
// done, response done and an error code.
// Timing: an accepted word is registered in the input register, decoded
// combinationally and registered again in the output register that drives the rsp_ channel.
// Throughput: one word per cycle while the receiver keeps rsp_tready high;
// the decoder updates its state once per word.
// When the receiver stalls, the result stays in the output register and
// the input register holds one more word; req_tready then drops.
// Reset (synchronous, active high) empties both registers and returns the
// decoder to idle; the next word should be an arm event.
module http_chunked_response_deframer_core #(
   parameter int SIZE_DIGITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data
   input  logic [0:0]  req_tuser,  // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [7:0] payload_byte, [8] header_done,
                                   // [9] response_done, [12:10] error_code
   output logic [0:0]  rsp_tuser,  // [0] payload_valid
   output logic        rsp_tlast   // chunk_last
);
   import hcrd_pkg::*;

   logic       in_valid_ff;
   logic       kind_ff;
   logic [7:0] data_ff;
   logic       advance;
   logic       step;
   result_type result;
   result_type held;

   // The input register moves on whenever the output register is free.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff <= req_tuser[0];
         data_ff <= req_tdata;
      end
   end

   hcrd_decoder #(
      .SIZE_DIGITS(SIZE_DIGITS)
   ) u_decoder (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .kind  (kind_ff),
      .data  (data_ff),
      .result(result)
   );

   hcrd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .result    (result),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .held      (held)
   );

   // Pack the result word onto the stream ports.
   assign rsp_tdata = {3'd0, held.error_code, held.response_done, held.header_done,
                       held.payload_byte};
   assign rsp_tuser = held.payload_valid;
   assign rsp_tlast = held.chunk_last;

endmodule
